### rtl/core/telnet_iac_flow_detector_top_defines.svh
// Assertion helpers for the telnet IAC flow detector.
// Both expect clk and arst_n in scope.
`ifndef TELNET_IAC_FLOW_DETECTOR_TOP_DEFINES_SVH
`define TELNET_IAC_FLOW_DETECTOR_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define TIAD_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tiad: check failed");

// Consequent must hold in the cycle after the antecedent.
`define TIAD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tiad: sequence check failed");

`endif

### rtl/core/tiad_pkg.sv
`timescale 1ns / 1ps
package tiad_pkg;

	localparam int MAX_PAYLOAD = 65535;

	// Queue between classifier and verdict logic
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Byte positions within a packet
	localparam int HDR_POS  = 2;
	localparam int BODY_POS = 5;
	localparam int MIN_LEN  = 3;

	// Telnet byte codes
	localparam logic [7:0] IAC         = 8'hff;
	localparam logic [7:0] HDR_CMD_MIN = 8'hf9;
	localparam logic [7:0] HDR_OPT_LIM = 8'h28;
	localparam logic [7:0] CMD_LO      = 8'hf0;
	localparam logic [7:0] CMD_MID     = 8'hfa;
	localparam logic [7:0] NEG_LO      = 8'hfb;
	localparam logic [7:0] OPT_MAX     = 8'h28;

	// Verdict codes
	localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
	localparam logic [1:0] VERDICT_TELNET    = 2'd1;
	localparam logic [1:0] VERDICT_EXCLUDED  = 2'd2;
	localparam logic [1:0] STAGE_MAX         = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_CONFIRM_STAGE  = 2'd0;
	localparam logic [1:0] REG_EXCLUDE_PLAIN  = 2'd1;
	localparam logic [1:0] REG_EXCLUDE_STAGED = 2'd2;

	localparam logic [1:0] RST_CONFIRM_STAGE  = 2'd2;
	localparam logic [7:0] RST_EXCLUDE_PLAIN  = 8'd6;
	localparam logic [7:0] RST_EXCLUDE_STAGED = 8'd12;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] packet_number;
		logic       new_flow;
	} in_item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       packet_matched;
		logic [1:0] stage_now;
	} out_item_t;

	// One finished packet, handed from classifier to verdict logic
	typedef struct packed {
		logic       clear;
		logic       matched;
		logic [7:0] packet_number;
	} pkt_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [1:0] stage;
	} bk_status_t;

	function automatic logic header_good(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		return (b0 == IAC) && (b1 > HDR_CMD_MIN) && (b1 != IAC) && (b2 < HDR_OPT_LIM);
	endfunction

	function automatic logic body_good(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		logic plain_cmd;
		logic neg_cmd;
		plain_cmd = (b1 >= CMD_LO) && (b1 <= CMD_MID);
		neg_cmd   = (b1 >= NEG_LO) && (b1 != IAC) && (b2 <= OPT_MAX);
		return (b0 != IAC) || plain_cmd || neg_cmd;
	endfunction

endpackage

### rtl/core/tiad_front.sv
`timescale 1ns / 1ps
module tiad_front import tiad_pkg::*; #(
	parameter int MaxPayload = MAX_PAYLOAD
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_stall,
	input  in_item_t in_item,
	output logic     rec_push,
	output pkt_rec_t rec
);

	localparam int PosW = $clog2(MaxPayload + 1);

	logic [7:0]      win0_q;
	logic [7:0]      win1_q;
	logic [PosW-1:0] pos_q;
	logic            ok_q;
	logic            clear_q;

	logic            take;
	logic [PosW-1:0] pos_eff;
	logic            ok_eff;
	logic            clear_eff;
	logic            in_range;
	logic [PosW-1:0] pos_n;
	logic            ok_n;

	assign take = in_valid && !in_stall;

	always_comb begin
		pos_eff   = in_item.first_byte ? '0 : pos_q;
		ok_eff    = in_item.first_byte ? 1'b1 : ok_q;
		clear_eff = clear_q || (in_item.first_byte && in_item.new_flow);
		in_range  = 32'(pos_eff) < 32'(MaxPayload);
		ok_n      = ok_eff;
		if (in_range && (32'(pos_eff) == 32'(HDR_POS))
				&& !header_good(win0_q, win1_q, in_item.data_byte)) begin
			ok_n = 1'b0;
		end
		if (in_range && (32'(pos_eff) >= 32'(BODY_POS))
				&& !body_good(win0_q, win1_q, in_item.data_byte)) begin
			ok_n = 1'b0;
		end
		pos_n = in_range ? pos_eff + PosW'(1) : pos_eff;
	end

	assign rec_push          = take && in_item.last_byte;
	assign rec.clear         = clear_eff;
	assign rec.matched       = ok_n && (32'(pos_n) >= 32'(MIN_LEN));
	assign rec.packet_number = in_item.packet_number;

	// Window holds still once the packet runs past the payload limit
	always_ff @(posedge clk) begin
		if (take && in_range) begin
			win0_q <= win1_q;
			win1_q <= in_item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ok_q    <= 1'b1;
			clear_q <= 1'b0;
		end else if (take) begin
			if (in_item.last_byte) begin
				pos_q   <= '0;
				ok_q    <= 1'b1;
				clear_q <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				ok_q    <= ok_n;
				clear_q <= clear_eff;
			end
		end
	end

endmodule

### rtl/core/tiad_queue.sv
`timescale 1ns / 1ps
module tiad_queue import tiad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pkt_rec_t  push_rec,
	input  logic      pop,
	output pkt_rec_t  pop_rec,
	output q_status_t status
);

	pkt_rec_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign status.full  = (32'(count_q) == QUEUE_DEPTH);
	assign status.empty = (count_q == '0);
	assign pop_rec      = mem_q[rd_ptr_q];

	function automatic logic [QUEUE_AW-1:0] ptr_next(logic [QUEUE_AW-1:0] p);
		return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QUEUE_AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_CW'(1);
				2'b01:   count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/tiad_back.sv
`timescale 1ns / 1ps
module tiad_back import tiad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       rec_avail,
	input  pkt_rec_t   rec,
	output logic       rec_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	output bk_status_t status
);

	logic [1:0] confirm_stage_q;
	logic [7:0] excl_plain_q;
	logic [7:0] excl_staged_q;

	logic [1:0] stage_q;
	logic [1:0] verdict_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic [1:0] stage_in;
	logic [1:0] verdict_in;
	logic [1:0] stage_n;
	logic [1:0] verdict_n;
	logic       hold_off;

	// Refill the output register when a record waits and the register is empty or being taken
	assign rec_pop = rec_avail && (!out_valid_q || !out_stall);

	always_comb begin
		stage_in   = rec.clear ? 2'd0 : stage_q;
		verdict_in = rec.clear ? VERDICT_UNDECIDED : verdict_q;
		stage_n    = stage_in;
		verdict_n  = verdict_in;
		hold_off   = ((rec.packet_number < excl_staged_q) && (stage_in != 2'd0))
			|| (rec.packet_number < excl_plain_q);
		if (verdict_in == VERDICT_UNDECIDED) begin
			if (rec.matched) begin
				if (stage_in == confirm_stage_q) begin
					verdict_n = VERDICT_TELNET;
				end else if (stage_in < STAGE_MAX) begin
					stage_n = stage_in + 2'd1;
				end
			end else if (!hold_off) begin
				verdict_n = VERDICT_EXCLUDED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_stage_q <= RST_CONFIRM_STAGE;
			excl_plain_q    <= RST_EXCLUDE_PLAIN;
			excl_staged_q   <= RST_EXCLUDE_STAGED;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONFIRM_STAGE:  confirm_stage_q <= cfg_data[1:0];
				REG_EXCLUDE_PLAIN:  excl_plain_q    <= cfg_data;
				REG_EXCLUDE_STAGED: excl_staged_q   <= cfg_data;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= 2'd0;
			verdict_q   <= VERDICT_UNDECIDED;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_pop) begin
				stage_q     <= stage_n;
				verdict_q   <= verdict_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			out_q.verdict        <= verdict_n;
			out_q.packet_matched <= rec.matched;
			out_q.stage_now      <= stage_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_item       = out_q;
	assign status.verdict = verdict_q;
	assign status.stage   = stage_q;

endmodule

### rtl/core/telnet_iac_flow_detector_top.sv
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_item   (one payload byte)
// out     | output    | out_valid/out_stall | out_item  (one verdict per packet)
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low. A packet's verdict passes the
// packet queue, written as its last byte transfers, and then the output register,
// loaded from the queue head while that register is empty or being taken. in_stall
// rises only while the packet queue is full, i.e. once two verdicts wait in the
// queue behind a stalled output register. Reset is asynchronous and needs no clearing
// pass; configuration takes effect on the next record the verdict logic pops.
`include "telnet_iac_flow_detector_top_defines.svh"
module telnet_iac_flow_detector_top import tiad_pkg::*; #(
	parameter int MaxPayload = MAX_PAYLOAD
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic       q_push;
	pkt_rec_t   q_push_rec;
	logic       q_pop;
	pkt_rec_t   q_pop_rec;
	q_status_t  q_status;
	bk_status_t bk_status;
	logic       verdict_locked;

	assign in_stall = q_status.full;

	// A decided flow keeps stage and verdict unless a new flow is popped
	assign verdict_locked = (bk_status.verdict != VERDICT_UNDECIDED)
		&& !(q_pop && q_pop_rec.clear);

	tiad_front #(
		.MaxPayload(MaxPayload)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.rec_push (q_push),
		.rec      (q_push_rec)
	);

	tiad_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_push_rec),
		.pop      (q_pop),
		.pop_rec  (q_pop_rec),
		.status   (q_status)
	);

	tiad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec_avail (!q_status.empty),
		.rec       (q_pop_rec),
		.rec_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.status    (bk_status)
	);

	`TIAD_ASSERT(a_queue_sane, !(q_status.full && q_status.empty))
	`TIAD_ASSERT(a_verdict_code, !out_valid || (out_item.verdict <= VERDICT_EXCLUDED))
	`TIAD_ASSERT_NEXT(a_verdict_held, verdict_locked, $stable(bk_status.verdict) && $stable(bk_status.stage))

endmodule
